>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every clock edge, except while reset is held.
`define ITPAR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks a property on every clock edge, reset included.
`define ITPAR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hdl/itpar_pkg.sv
package itpar_pkg;

  localparam int unsigned MAX_LEN_DEF = 1023;
  localparam int unsigned STOP_W      = 10;
  localparam int unsigned VALUE_W     = 32;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned OUT_DATA_W  = 48;
  localparam int unsigned OUT_PAD_W   = OUT_DATA_W - VALUE_W - STOP_W - 2;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UA    = 8'h41;
  localparam logic [7:0] CH_UB    = 8'h42;
  localparam logic [7:0] CH_UF    = 8'h46;
  localparam logic [7:0] CH_UO    = 8'h4F;
  localparam logic [7:0] CH_UX    = 8'h58;
  localparam logic [7:0] CH_LA    = 8'h61;
  localparam logic [7:0] CH_LB    = 8'h62;
  localparam logic [7:0] CH_LF    = 8'h66;
  localparam logic [7:0] CH_LO    = 8'h6F;
  localparam logic [7:0] CH_LX    = 8'h78;

  typedef enum logic [4:0] {
    PH_LEAD     = 5'b00001,
    PH_POSTSIGN = 5'b00010,
    PH_ZERO     = 5'b00100,
    PH_DIGITS   = 5'b01000,
    PH_DONE     = 5'b10000
  } phase_t;

  typedef enum logic [1:0] {
    RX_DEC = 2'd0,
    RX_OCT = 2'd1,
    RX_HEX = 2'd2,
    RX_BIN = 2'd3
  } radix_t;

  typedef struct packed {
    logic              start_req;
    logic [CHAR_W-1:0] char_in;
  } item_t;

  typedef struct packed {
    radix_t                     radix_used;
    logic [STOP_W-1:0]          stop_pos;
    logic signed [VALUE_W-1:0]  value;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic digit_t digit_of(logic [7:0] c, radix_t rx);
    digit_t d;
    d.ok  = 1'b0;
    d.val = 4'd0;
    case (rx)
      RX_DEC: begin
        if (c >= CH_0 && c <= CH_9) begin
          d.ok  = 1'b1;
          d.val = 4'(c - CH_0);
        end
      end
      RX_OCT: begin
        if (c >= CH_0 && c <= CH_7) begin
          d.ok  = 1'b1;
          d.val = 4'(c - CH_0);
        end
      end
      RX_BIN: begin
        if (c >= CH_0 && c <= CH_1) begin
          d.ok  = 1'b1;
          d.val = 4'(c - CH_0);
        end
      end
      default: begin
        if (c >= CH_0 && c <= CH_9) begin
          d.ok  = 1'b1;
          d.val = 4'(c - CH_0);
        end else if (c >= CH_UA && c <= CH_UF) begin
          d.ok  = 1'b1;
          d.val = 4'(c - CH_UA + 8'd10);
        end else if (c >= CH_LA && c <= CH_LF) begin
          d.ok  = 1'b1;
          d.val = 4'(c - CH_LA + 8'd10);
        end
      end
    endcase
    return d;
  endfunction

  // Multiply by the radix with shifts only (decimal adds two shifts), then add the digit.
  function automatic logic [VALUE_W-1:0] acc_step(logic [VALUE_W-1:0] acc, radix_t rx,
                                                  logic [3:0] dig);
    logic [VALUE_W-1:0] scaled;
    case (rx)
      RX_OCT:  scaled = acc << 3;
      RX_HEX:  scaled = acc << 4;
      RX_BIN:  scaled = acc << 1;
      default: scaled = (acc << 3) + (acc << 1);
    endcase
    return scaled + VALUE_W'(dig);
  endfunction

endpackage

>>> hdl/integer_text_parser_auto_radix_top.sv
// Channel  Direction  Beat contents
// in_      slave      tdata: text byte; tuser: first byte of a new text
// out_     master     tdata: value, stop position, radix; one beat per finished text
//
// One byte is taken every cycle unless the output stalls; a byte waits in the
// input register and its result, if any, goes to the output register when it
// leaves. The state update (shift-and-add into the accumulator) is combinational.
// Synchronous active-low reset empties both registers and leaves the parser idle.
// A stalled output holds both stages; the input still takes a byte while its
// register is empty.
module integer_text_parser_auto_radix_top #(
  parameter int unsigned MAX_LEN = itpar_pkg::MAX_LEN_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [itpar_pkg::CHAR_W-1:0]      in_tdata,   // [7:0] char_in
  input  logic [0:0]                        in_tuser,   // [0] start_req
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [itpar_pkg::OUT_DATA_W-1:0]  out_tdata   // [31:0] value, [41:32] stop_pos,
                                                        // [43:42] radix_used, rest zero
);
  import itpar_pkg::*;

  item_t   in_item;
  item_t   item;
  logic    item_valid;
  logic    advance;
  logic    fire;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign in_item.char_in   = in_tdata;
  assign in_item.start_req = in_tuser[0];
  assign fire              = item_valid && advance;

  itpar_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  itpar_core #(
    .MAX_LEN (MAX_LEN)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (item),
    .res_valid (res_valid),
    .res       (res)
  );

  itpar_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_res.radix_used, out_res.stop_pos, out_res.value};

endmodule

>>> hdl/itpar_in_reg.sv
module itpar_in_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  itpar_pkg::item_t       in_item,
  input  logic                   advance,
  output logic                   item_valid,
  output itpar_pkg::item_t       item
);
  import itpar_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r;

  assign in_ready   = !valid_r || advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (advance) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

>>> hdl/itpar_core.sv
`include "assert_macros.svh"

module itpar_core #(
  parameter int unsigned MAX_LEN = itpar_pkg::MAX_LEN_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   fire,
  input  itpar_pkg::item_t       item,
  output logic                   res_valid,
  output itpar_pkg::result_t     res
);
  import itpar_pkg::*;

  localparam int unsigned POS_W = $clog2(MAX_LEN + 1);

  phase_t             phase_r, phase_nxt;
  radix_t             radix_r, radix_nxt;
  logic [VALUE_W-1:0] acc_r, acc_nxt;
  logic               neg_r, neg_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;

  phase_t             ph_b;
  radix_t             rx_b;
  radix_t             zero_rx;
  radix_t             step_rx;
  logic [VALUE_W-1:0] acc_b;
  logic               neg_b;
  logic [POS_W-1:0]   pos_b;
  logic [7:0]         c;
  logic               active;
  logic               stop;
  logic               do_step;
  digit_t             dig;
  logic [VALUE_W-1:0] acc_stepped;
  logic [POS_W+STOP_W-1:0] pos_ext;

  assign c = item.char_in;

  always_comb begin
    if (item.start_req) begin
      ph_b  = PH_LEAD;
      rx_b  = RX_DEC;
      acc_b = '0;
      neg_b = 1'b0;
      pos_b = '0;
    end else begin
      ph_b  = phase_r;
      rx_b  = radix_r;
      acc_b = acc_r;
      neg_b = neg_r;
      pos_b = pos_r;
    end
  end

  always_comb begin
    case (c) inside
      [CH_0:CH_7], CH_LO, CH_UO: zero_rx = RX_OCT;
      CH_LX, CH_UX:              zero_rx = RX_HEX;
      CH_LB, CH_UB:              zero_rx = RX_BIN;
      default:                   zero_rx = RX_DEC;
    endcase
  end

  assign step_rx     = (ph_b == PH_ZERO) ? zero_rx : rx_b;
  assign dig         = digit_of(c, step_rx);
  assign acc_stepped = acc_step(acc_b, step_rx, dig.val);

  always_comb begin
    active    = fire && (item.start_req || phase_r != PH_DONE);
    phase_nxt = phase_r;
    radix_nxt = radix_r;
    acc_nxt   = acc_r;
    neg_nxt   = neg_r;
    pos_nxt   = pos_r;
    stop      = 1'b0;
    do_step   = 1'b0;
    if (active) begin
      phase_nxt = ph_b;
      radix_nxt = rx_b;
      acc_nxt   = acc_b;
      neg_nxt   = neg_b;
      pos_nxt   = pos_b;
      if (c == CH_NUL) begin
        stop = 1'b1;
      end else begin
        case (ph_b)
          PH_LEAD, PH_POSTSIGN: begin
            if (c == CH_SPACE) begin
              phase_nxt = ph_b;
            end else if (ph_b == PH_LEAD && c == CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_POSTSIGN;
            end else if (ph_b == PH_LEAD && c == CH_PLUS) begin
              phase_nxt = PH_POSTSIGN;
            end else if (c == CH_0) begin
              phase_nxt = PH_ZERO;
            end else begin
              phase_nxt = PH_DIGITS;
              do_step   = 1'b1;
            end
          end
          PH_ZERO: begin
            phase_nxt = PH_DIGITS;
            radix_nxt = zero_rx;
            case (c) inside
              CH_LO, CH_UO, CH_LX, CH_UX, CH_LB, CH_UB: do_step = 1'b0;
              default:                                  do_step = 1'b1;
            endcase
          end
          default: begin
            do_step = 1'b1;
          end
        endcase
        if (do_step && c != CH_SPACE) begin
          if (!dig.ok) begin
            stop = 1'b1;
          end else begin
            acc_nxt = acc_stepped;
          end
        end
      end
      if (stop) begin
        phase_nxt = PH_DONE;
      end else if (pos_b < POS_W'(MAX_LEN)) begin
        pos_nxt = pos_b + POS_W'(1);
      end else begin
        pos_nxt = POS_W'(MAX_LEN);
      end
    end
  end

  // A stopping byte never changes the sign or the accumulator.
  assign pos_ext        = {{STOP_W{1'b0}}, pos_b};
  assign res_valid      = active && stop;
  assign res.value      = neg_b ? (VALUE_W'(0) - acc_b) : acc_b;
  assign res.stop_pos   = pos_ext[STOP_W-1:0];
  assign res.radix_used = radix_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_DONE;
      radix_r <= RX_DEC;
      acc_r   <= '0;
      neg_r   <= 1'b0;
      pos_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      radix_r <= radix_nxt;
      acc_r   <= acc_nxt;
      neg_r   <= neg_nxt;
      pos_r   <= pos_nxt;
    end
  end

  `ITPAR_ASSERT(a_no_result_when_done,
    (fire && !item.start_req && phase_r == PH_DONE) |-> !res_valid,
    "result produced for a byte outside any text")
  `ITPAR_ASSERT(a_done_after_result, res_valid |=> (phase_r == PH_DONE),
    "parser did not stop after its result")
  `ITPAR_ASSERT(a_start_restarts_pos, (fire && item.start_req) |=> (pos_r <= POS_W'(1)),
    "start byte did not restart the position count")

endmodule

>>> hdl/itpar_out_reg.sv
module itpar_out_reg (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   res_valid,
  input  itpar_pkg::result_t     res,
  output logic                   advance,
  output logic                   out_valid,
  input  logic                   out_ready,
  output itpar_pkg::result_t     out_res
);
  import itpar_pkg::*;

  logic    valid_r, valid_nxt;
  result_t res_r;

  assign advance   = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (advance) begin
      valid_nxt = res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

endmodule
